/* hdl/csa_pkg.sv */
// Package with the command codes, stack operation codes and shared types of the cell stack unit.
package csa_pkg;

  // Command codes carried by an input item.
  typedef enum logic [3:0] {
    CMD_POP  = 4'd0,
    CMD_PUSH = 4'd1,
    CMD_PEEK = 4'd2,
    CMD_DROP = 4'd3,
    CMD_ADD  = 4'd4,
    CMD_SUB  = 4'd5,
    CMD_SHL  = 4'd6,
    CMD_SHR  = 4'd7,
    CMD_OR   = 4'd8,
    CMD_XOR  = 4'd9,
    CMD_AND  = 4'd10
  } cmd_t;

  // Cell width select codes.
  localparam logic [1:0] SIZE_8  = 2'd0;
  localparam logic [1:0] SIZE_16 = 2'd1;
  localparam logic [1:0] SIZE_32 = 2'd2;
  localparam logic [1:0] SIZE_64 = 2'd3;

  // What an item does to the stack pointer.
  typedef enum logic [1:0] {
    SOP_NONE = 2'd0,
    SOP_PUSH = 2'd1,
    SOP_POP  = 2'd2
  } sop_t;

  // Status of the stack before the current item.
  typedef struct packed {
    logic has_top;
    logic full;
  } stk_stat_t;

  // Result of the datapath for one item.
  typedef struct packed {
    logic [63:0] new_cell;
    logic        written;
    logic        overflow;
    sop_t        sop;
  } alu_res_t;

endpackage

/* hdl/csa_alu.sv */
// Combinational datapath: decodes the command and combines the cell with the top of stack.
module csa_alu (
  input  logic [1:0]         cell_size,
  input  logic [3:0]         cmd,
  input  logic [63:0]        cell_value,
  input  logic [63:0]        top_value,
  input  csa_pkg::stk_stat_t stat,
  output csa_pkg::alu_res_t  res
);

  logic [63:0] mask;
  logic [6:0]  width;
  logic [63:0] cell_m;
  logic [63:0] top_m;
  logic        shift_big;
  logic [63:0] result;

  // Width mask for the selected cell size.
  always_comb begin
    case (cell_size)
      csa_pkg::SIZE_8: begin
        mask  = 64'h0000_0000_0000_00FF;
        width = 7'd8;
      end
      csa_pkg::SIZE_16: begin
        mask  = 64'h0000_0000_0000_FFFF;
        width = 7'd16;
      end
      csa_pkg::SIZE_32: begin
        mask  = 64'h0000_0000_FFFF_FFFF;
        width = 7'd32;
      end
      default: begin
        mask  = 64'hFFFF_FFFF_FFFF_FFFF;
        width = 7'd64;
      end
    endcase
  end

  assign cell_m    = cell_value & mask;
  assign top_m     = stat.has_top ? (top_value & mask) : 64'd0;
  assign shift_big = top_m >= {57'd0, width};

  // Command decode and operation select.
  always_comb begin
    result       = cell_m;
    res.written  = 1'b0;
    res.overflow = 1'b0;
    res.sop      = csa_pkg::SOP_NONE;
    case (csa_pkg::cmd_t'(cmd))
      csa_pkg::CMD_POP: begin
        result      = top_m;
        res.written = 1'b1;
        if (stat.has_top) begin
          res.sop = csa_pkg::SOP_POP;
        end
      end
      csa_pkg::CMD_PUSH: begin
        if (stat.full) begin
          res.overflow = 1'b1;
        end else begin
          res.sop = csa_pkg::SOP_PUSH;
        end
      end
      csa_pkg::CMD_PEEK: begin
        result      = top_m;
        res.written = 1'b1;
      end
      csa_pkg::CMD_DROP: begin
        if (stat.has_top) begin
          res.sop = csa_pkg::SOP_POP;
        end
      end
      csa_pkg::CMD_ADD: begin
        if (stat.has_top) begin
          result      = cell_m + top_m;
          res.written = 1'b1;
        end
      end
      csa_pkg::CMD_SUB: begin
        if (stat.has_top) begin
          result      = cell_m - top_m;
          res.written = 1'b1;
        end
      end
      csa_pkg::CMD_SHL: begin
        if (stat.has_top) begin
          result      = shift_big ? 64'd0 : (cell_m << top_m[5:0]);
          res.written = 1'b1;
        end
      end
      csa_pkg::CMD_SHR: begin
        if (stat.has_top) begin
          result      = shift_big ? 64'd0 : (cell_m >> top_m[5:0]);
          res.written = 1'b1;
        end
      end
      csa_pkg::CMD_OR: begin
        if (stat.has_top) begin
          result      = cell_m | top_m;
          res.written = 1'b1;
        end
      end
      csa_pkg::CMD_XOR: begin
        if (stat.has_top) begin
          result      = cell_m ^ top_m;
          res.written = 1'b1;
        end
      end
      csa_pkg::CMD_AND: begin
        // An empty stack makes this 0, since the top reads as 0.
        result      = cell_m & top_m;
        res.written = 1'b1;
      end
      default: begin
        result = cell_m;
      end
    endcase
    res.new_cell = result & mask;
  end

endmodule

/* hdl/csa_stack.sv */
// Stack memory with fill count and a cached top of stack.
module csa_stack #(
  parameter int STACK_DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  csa_pkg::sop_t                         sop,
  input  logic [63:0]                           push_data,
  output logic [63:0]                           top_value,
  output csa_pkg::stk_stat_t                    stat,
  output logic [$clog2(STACK_DEPTH + 1) - 1:0]  fill_next
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int FW = $clog2(STACK_DEPTH + 1);

  logic [63:0]   mem [STACK_DEPTH];
  logic [FW-1:0] fill_r;
  logic [FW-1:0] fill_nxt;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic          do_push;
  logic [63:0]   rd_r;
  logic          byp_r;
  logic [63:0]   byp_val_r;

  assign stat.has_top = fill_r != '0;
  assign stat.full    = fill_r == FW'(STACK_DEPTH);
  assign do_push      = en && (sop == csa_pkg::SOP_PUSH);
  assign waddr        = AW'(fill_r);

  // Fill count after this cycle's item.
  always_comb begin
    fill_nxt = fill_r;
    if (en) begin
      case (sop)
        csa_pkg::SOP_PUSH: fill_nxt = fill_r + FW'(1);
        csa_pkg::SOP_POP:  fill_nxt = fill_r - FW'(1);
        default:           fill_nxt = fill_r;
      endcase
    end
  end

  assign fill_next = fill_nxt;

  // The read port always fetches the entry that will be on top next cycle.
  always_comb begin
    if (fill_nxt == '0) begin
      raddr = '0;
    end else begin
      raddr = AW'(fill_nxt - FW'(1));
    end
  end

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[waddr] <= push_data;
      byp_val_r  <= push_data;
    end
    rd_r <= mem[raddr];
  end

  // Fill count and bypass flag for a value pushed in the previous cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      byp_r  <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      byp_r  <= do_push;
    end
  end

  assign top_value = byp_r ? byp_val_r : rd_r;

endmodule

/* hdl/cell_stack_alu_unit_core.sv */
// Top level of the cell stack unit: input register, datapath, stack and result register.
//
// The unit takes one item per clock cycle while the result side does not stall, and presents
// its result from the result register: the accepting edge loads the input register, which
// passes the item on to the result register once that register is free. The stack
// lives in a single-port-write, single-port-read memory of STACK_DEPTH 64-bit entries whose
// read port always fetches the entry that will be on top in the next cycle; a value pushed
// in the previous cycle is served from a bypass register, so pushes, pops and arithmetic on
// the top of stack may follow one another every cycle. Stalls on the result side hold the
// input register. The memory needs no clearing pass after reset, as only pushed entries are
// ever used. The cell width is set through cfg_wr_en and cfg_wr_data and must only be
// changed while the unit is idle.
module cell_stack_alu_unit_core #(
  parameter int STACK_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_cmd,
  input  logic [63:0] in_cell_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_new_cell,
  output logic        out_cell_written,
  output logic        out_stack_empty,
  output logic        out_push_overflow,
  output logic [8:0]  out_stack_count
);

  localparam int FW = $clog2(STACK_DEPTH + 1);

  logic [1:0]         cfg_size_r;
  logic               s1_valid_r;
  logic [3:0]         s1_cmd_r;
  logic [63:0]        s1_cell_r;
  logic               out_valid_r;
  logic [63:0]        out_new_cell_r;
  logic               out_written_r;
  logic               out_empty_r;
  logic               out_overflow_r;
  logic [8:0]         out_count_r;
  logic               advance;
  logic [63:0]        top_value;
  csa_pkg::stk_stat_t stat;
  csa_pkg::alu_res_t  res;
  logic [FW-1:0]      fill_next;
  logic [FW+8:0]      fill_ext;

  // Handshake: the input register moves on whenever the result register is free.
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_size_r <= csa_pkg::SIZE_8;
    end else if (cfg_wr_en) begin
      cfg_size_r <= cfg_wr_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd_r  <= in_cmd;
      s1_cell_r <= in_cell_value;
    end
  end

  csa_alu u_alu (
    .cell_size  (cfg_size_r),
    .cmd        (s1_cmd_r),
    .cell_value (s1_cell_r),
    .top_value  (top_value),
    .stat       (stat),
    .res        (res)
  );

  csa_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (advance),
    .sop        (res.sop),
    .push_data  (res.new_cell),
    .top_value  (top_value),
    .stat       (stat),
    .fill_next  (fill_next)
  );

  assign fill_ext = {9'd0, fill_next};

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_new_cell_r <= res.new_cell;
      out_written_r  <= res.written;
      out_overflow_r <= res.overflow;
      out_empty_r    <= fill_next == '0;
      out_count_r    <= fill_ext[8:0];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_new_cell      = out_new_cell_r;
  assign out_cell_written  = out_written_r;
  assign out_stack_empty   = out_empty_r;
  assign out_push_overflow = out_overflow_r;
  assign out_stack_count   = out_count_r;

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the cell stack unit, with a mirrored stack that predicts every result.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import csa_pkg::*;

  localparam int STACK_DEPTH = 256;
  localparam int CLK_PERIOD = 10;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 6;
  localparam int MAX_WAIT = 13;
  localparam int RANDOM_PHASES = 7;
  localparam int ITEMS_PER_PHASE = 65;
  // Highest code that the four-bit command field can carry; codes above and
  // including CMD_AND + 1 are unused.
  localparam int CMD_TOP_CODE = 15;
  // Widths visited by the first phases, so that both extremes come early.
  localparam logic [1:0] PHASE_SIZES [4] = '{SIZE_64, SIZE_16, SIZE_32, SIZE_8};

  // One command for the stack with the tape cell beside it.
  typedef struct packed {
    logic [3:0]  cmd;
    logic [63:0] value;
  } stack_cmd_t;

  // What the unit should answer for one item.
  typedef struct packed {
    logic [63:0] new_cell;
    logic        written;
    logic        empty;
    logic        overflow;
    logic [8:0]  count;
  } cell_answer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_wr_data = SIZE_8;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [3:0]  in_cmd = CMD_POP;
  logic [63:0] in_cell_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_new_cell;
  logic        out_cell_written;
  logic        out_stack_empty;
  logic        out_push_overflow;
  logic [8:0]  out_stack_count;

  stack_cmd_t   pending_cmds[$];
  cell_answer_t expected_answers[$];
  stack_cmd_t   next_cmd;
  cell_answer_t seen_answer;
  cell_answer_t want_answer;

  // Mirror of the stack contents, its level and the cell width select.
  logic [63:0] mirror_store [STACK_DEPTH];
  int unsigned mirror_fill = 0;
  logic [1:0]  mirror_size = SIZE_8;

  int in_idle_mode = 1;
  int out_idle_mode = 2;
  int in_gap = 0;
  int out_stall = 0;
  int errors = 0;
  int accepted = 0;
  int checked = 0;
  int full_pushes = 0;
  int peak_fill = 0;
  int cycles = 0;

  cell_stack_alu_unit_core #(
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_cell_value    (in_cell_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_new_cell     (out_new_cell),
    .out_cell_written (out_cell_written),
    .out_stack_empty  (out_stack_empty),
    .out_push_overflow(out_push_overflow),
    .out_stack_count  (out_stack_count)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Applies one command to the mirrored stack and returns the answer it should give.
  function automatic cell_answer_t apply_stack_cmd(logic [3:0] cmd, logic [63:0] value);
    int unsigned  width;
    logic [63:0]  mask;
    logic [63:0]  cell_v;
    logic [63:0]  top;
    logic         has_top;
    cell_answer_t ans;
    width = 8 << mirror_size;
    mask = (width == 64) ? '1 : ((64'd1 << width) - 64'd1);
    cell_v = value & mask;
    has_top = (mirror_fill != 0);
    top = has_top ? (mirror_store[mirror_fill - 1] & mask) : '0;
    ans.new_cell = cell_v;
    ans.written = 1'b0;
    ans.overflow = 1'b0;
    case (cmd)
      CMD_POP: begin
        ans.new_cell = top;
        ans.written = 1'b1;
        if (has_top) mirror_fill--;
      end
      CMD_PUSH: begin
        if (mirror_fill >= STACK_DEPTH) begin
          ans.overflow = 1'b1;
          full_pushes++;
        end else begin
          mirror_store[mirror_fill] = cell_v;
          mirror_fill++;
        end
      end
      CMD_PEEK: begin
        ans.new_cell = top;
        ans.written = 1'b1;
      end
      CMD_DROP: begin
        if (has_top) mirror_fill--;
      end
      CMD_ADD, CMD_SUB, CMD_SHL, CMD_SHR, CMD_OR, CMD_XOR: begin
        // With an empty stack the cell is left alone.
        if (has_top) begin
          ans.written = 1'b1;
          case (cmd)
            CMD_ADD: ans.new_cell = cell_v + top;
            CMD_SUB: ans.new_cell = cell_v - top;
            CMD_SHL: ans.new_cell = (top >= width) ? '0 : (cell_v << top[5:0]);
            CMD_SHR: ans.new_cell = (top >= width) ? '0 : (cell_v >> top[5:0]);
            CMD_OR:  ans.new_cell = cell_v | top;
            default: ans.new_cell = cell_v ^ top;
          endcase
        end
      end
      CMD_AND: begin
        ans.new_cell = has_top ? (cell_v & top) : '0;
        ans.written = 1'b1;
      end
      default: begin
      end
    endcase
    ans.new_cell = ans.new_cell & mask;
    ans.empty = (mirror_fill == 0);
    ans.count = 9'(mirror_fill);
    if (mirror_fill > peak_fill) peak_fill = mirror_fill;
    return ans;
  endfunction

  // Cell values: extremes, single bits, small amounts that make shifts count, and noise.
  function automatic logic [63:0] draw_cell_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 64'($urandom_range(0, 12));
      3: return 64'($urandom_range(0, 70));
      4: return 64'd1 << $urandom_range(0, 63);
      5: return (64'd1 << (8 << $urandom_range(0, 2))) - 64'd1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Commands weighted so that the stack level wanders up and down.
  function automatic logic [3:0] draw_cmd();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 26) return CMD_PUSH;
    else if (pick < 38) return CMD_POP;
    else if (pick < 44) return CMD_PEEK;
    else if (pick < 50) return CMD_DROP;
    else if (pick < 97) return 4'($urandom_range(CMD_ADD, CMD_AND));
    else return 4'($urandom_range(CMD_AND + 1, CMD_TOP_CODE));
  endfunction

  // Mode 0 never waits, mode 1 always may, mode 2 waits now and then.
  function automatic int draw_wait(int mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, MAX_WAIT);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_WAIT) : 0;
    endcase
  endfunction

  function automatic void queue_cmd(logic [3:0] cmd, logic [63:0] value);
    stack_cmd_t c;
    c.cmd = cmd;
    c.value = value;
    pending_cmds.insert(pending_cmds.size(), c);
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch on result %0d: %s is %h, expected %h", checked, what, got, want);
  endtask

  // Driver: presents queued items, predicting each one as it is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_answers.insert(expected_answers.size(),
                                apply_stack_cmd(in_cmd, in_cell_value));
        accepted++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          next_cmd = pending_cmds.pop_front();
          in_cmd <= next_cmd.cmd;
          in_cell_value <= next_cmd.value;
          in_valid <= 1'b1;
          if ($urandom_range(0, 39) == 0) in_idle_mode = $urandom_range(0, 2);
          in_gap = draw_wait(in_idle_mode);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: takes results, compares them with the oldest prediction and stalls at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        seen_answer.new_cell = out_new_cell;
        seen_answer.written = out_cell_written;
        seen_answer.empty = out_stack_empty;
        seen_answer.overflow = out_push_overflow;
        seen_answer.count = out_stack_count;
        if (expected_answers.size() == 0) begin
          report_mismatch("result with nothing expected", seen_answer.new_cell, '0);
        end else begin
          want_answer = expected_answers.pop_front();
          if (seen_answer.new_cell !== want_answer.new_cell)
            report_mismatch("new_cell", seen_answer.new_cell, want_answer.new_cell);
          if (seen_answer.written !== want_answer.written)
            report_mismatch("cell_written", 64'(seen_answer.written), 64'(want_answer.written));
          if (seen_answer.empty !== want_answer.empty)
            report_mismatch("stack_empty", 64'(seen_answer.empty), 64'(want_answer.empty));
          if (seen_answer.overflow !== want_answer.overflow)
            report_mismatch("push_overflow", 64'(seen_answer.overflow),
                            64'(want_answer.overflow));
          if (seen_answer.count !== want_answer.count)
            report_mismatch("stack_count", 64'(seen_answer.count), 64'(want_answer.count));
        end
        checked++;
        if ($urandom_range(0, 39) == 0) out_idle_mode = $urandom_range(0, 2);
        out_stall = draw_wait(out_idle_mode);
      end else if (out_stall > 0) begin
        out_stall--;
      end
      out_ready <= (out_stall == 0);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles with %0d results outstanding",
               cycles, expected_answers.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic wait_for_idle();
    while (pending_cmds.size() != 0 || in_valid || expected_answers.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cell_size(logic [1:0] size);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= size;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    mirror_size = size;
  endtask

  initial begin
    int phase;
    logic [1:0] size;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items at the reset width of 8 bits: empty stack first, then each operation.
    queue_cmd(CMD_POP, 64'h55);
    queue_cmd(CMD_PEEK, 64'hAA);
    queue_cmd(CMD_DROP, '0);
    queue_cmd(CMD_ADD, 64'h12);
    queue_cmd(CMD_SHR, '1);
    queue_cmd(CMD_AND, '1);
    queue_cmd(4'(CMD_TOP_CODE), '1);
    queue_cmd(CMD_PUSH, '1);
    queue_cmd(CMD_ADD, 64'h01);
    queue_cmd(CMD_SUB, 64'h00);
    queue_cmd(CMD_OR, 64'hF0);
    queue_cmd(CMD_XOR, 64'h0F);
    queue_cmd(CMD_AND, 64'h3C);
    queue_cmd(CMD_PUSH, 64'd7);
    queue_cmd(CMD_SHL, 64'h03);
    queue_cmd(CMD_SHR, 64'h80);
    queue_cmd(CMD_PUSH, 64'd8);
    queue_cmd(CMD_SHL, 64'hFF);
    queue_cmd(CMD_SHR, 64'hFF);
    queue_cmd(CMD_PEEK, '0);
    queue_cmd(CMD_POP, '0);
    queue_cmd(CMD_DROP, '0);
    queue_cmd(4'(CMD_AND + 1), '0);
    queue_cmd(CMD_POP, '0);
    queue_cmd(CMD_POP, '0);
    wait_for_idle();

    // Random phases, each at its own cell width.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      size = (phase < 4) ? PHASE_SIZES[phase] : 2'($urandom_range(SIZE_8, SIZE_64));
      write_cell_size(size);
      if (phase == 0) begin
        // Fill the stack past its depth, then work on the top while it is full.
        repeat (STACK_DEPTH + 2) queue_cmd(CMD_PUSH, draw_cell_value());
        repeat (6) queue_cmd(4'($urandom_range(CMD_ADD, CMD_AND)), draw_cell_value());
        queue_cmd(CMD_PUSH, draw_cell_value());
      end else if (phase == 3) begin
        // Drain it completely at the narrowest width, running off the bottom.
        repeat (STACK_DEPTH + 4)
          queue_cmd($urandom_range(0, 1) ? CMD_POP : CMD_DROP, draw_cell_value());
      end
      repeat (ITEMS_PER_PHASE) queue_cmd(draw_cmd(), draw_cell_value());
      wait_for_idle();
    end

    $display("run covered %0d items and %0d results over %0d width phases",
             accepted, checked, RANDOM_PHASES + 1);
    $display("%0d pushes met a full stack; the stack reached %0d entries",
             full_pushes, peak_fill);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
